### rtl/core/kct_pkg.sv
// Shared types and constants for the keyed count table.
// No dependencies; compile first.
`default_nettype none

package kct_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_W     = 32;
   localparam int AMT_W     = 31;
   localparam int SLOT_W    = 4;
   localparam int STATUS_W  = 3;
   localparam int ENTRIES_W = 5;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   // width used to compare a slot number against the entry count
   localparam int CMP_W     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [AMT_W-1:0]        amount_type;
   typedef logic [CNT_W-1:0]        count_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_UPDATE = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_DUP     = 3'd2,
      ST_NEG     = 3'd3,
      ST_MISSING = 3'd4,
      ST_EMPTY   = 3'd5
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } state_type;

   // command broadcast to every cell in the row
   typedef struct packed {
      logic insert_go;
      logic update_go;
      logic remove_go;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/core/kct_req_if.sv
// Request channel: operation word into the table.
// Depends on kct_pkg.
`default_nettype none

interface kct_req_if;
   import kct_pkg::*;

   logic                valid;
   logic                ready;
   op_type              operation;
   logic signed [31:0]  key;
   logic signed [31:0]  amount;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, operation, key, amount, slot, input ready);
   modport sink   (input valid, operation, key, amount, slot, output ready);
endinterface

`default_nettype wire

### rtl/core/kct_rsp_if.sv
// Response channel: status word out of the table.
// Depends on kct_pkg.
`default_nettype none

interface kct_rsp_if;
   import kct_pkg::*;

   logic                  valid;
   logic                  ready;
   status_type            status;
   logic signed [31:0]    key_out;
   logic [AMT_W-1:0]      amount_out;
   logic [ENTRIES_W-1:0]  entries;

   modport source (output valid, status, key_out, amount_out, entries, input ready);
   modport sink   (input valid, status, key_out, amount_out, entries, output ready);
endinterface

`default_nettype wire

### rtl/core/keyed_count_table.sv
// Keyed count table: packed DEPTH-cell row, search/insert/update/remove/read.
// A request word is taken only in IDLE and registered; the compare-and-apply
// step across the cell row runs in EXEC and loads the registered result,
// stalling on a full output. No new word is taken until the last is applied.
// Reset (synchronous): clears entry count, control state and output valid;
// cell contents are not cleared and only entries below the count are used.
`default_nettype none

module keyed_count_table (
   input  wire logic  clock,
   input  wire logic  reset,
   kct_req_if.sink    req_bus,
   kct_rsp_if.source  rsp_bus
);
   import kct_pkg::*;

   state_type  state_ff, state_in;
   op_type     op_ff;
   key_type    key_ff;
   logic signed [31:0] amt_ff;
   logic [SLOT_W-1:0]  slot_ff;
   count_type  count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   key_type               rsp_key_ff, rsp_key_in;
   amount_type            rsp_amount_ff, rsp_amount_in;
   logic [ENTRIES_W-1:0]  rsp_entries_ff, rsp_entries_in;

   cmd_type    cmd;
   logic       can_load;
   logic       any_match;
   logic       full;
   logic       neg;
   logic       slot_hit;
   key_type    rd_key;
   amount_type rd_amount;
   amount_type amt_low;

   logic       seen [DEPTH+1];
   key_type    cell_key    [DEPTH];
   amount_type cell_amount [DEPTH];

   assign seen[0] = 1'b0;

   assign amt_low = amt_ff[AMT_W-1:0];

   genvar j;
   generate
      for (j = 0; j < DEPTH; j++) begin : g_cell
         key_type    nb_key;
         amount_type nb_amount;
         if (j == DEPTH - 1) begin : g_last
            assign nb_key    = '0;
            assign nb_amount = '0;
         end else begin : g_mid
            assign nb_key    = cell_key[j+1];
            assign nb_amount = cell_amount[j+1];
         end
         kct_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .key_in      (key_ff),
            .amount_in   (amt_low),
            .valid       (CNT_W'(j) < count_ff),
            .tail        (CNT_W'(j) == count_ff),
            .seen_in     (seen[j]),
            .next_key    (nb_key),
            .next_amount (nb_amount),
            .seen_out    (seen[j+1]),
            .key_out     (cell_key[j]),
            .amount_out  (cell_amount[j])
         );
      end
   endgenerate

   assign any_match = seen[DEPTH];
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign neg       = amt_ff[31];
   assign slot_hit  = (CMP_W'(slot_ff) < CMP_W'(count_ff));
   assign can_load  = !rsp_valid_ff || rsp_bus.ready;

   // read select over the row
   always_comb begin
      rd_key    = '0;
      rd_amount = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CMP_W'(i) == CMP_W'(slot_ff)) begin
            rd_key    = rd_key | cell_key[i];
            rd_amount = rd_amount | cell_amount[i];
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cmd            = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_amount_in  = rsp_amount_ff;
      rsp_entries_in = rsp_entries_ff;
      req_bus.ready  = (state_ff == FSM_IDLE);

      case (state_ff)
         FSM_IDLE: begin
            if (req_bus.valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (can_load) begin
               rsp_status_in = ST_OK;
               rsp_key_in    = '0;
               rsp_amount_in = '0;
               case (op_ff)
                  OP_INSERT: begin
                     if (full)           rsp_status_in = ST_FULL;
                     else if (any_match) rsp_status_in = ST_DUP;
                     else if (neg)       rsp_status_in = ST_NEG;
                     else                cmd.insert_go = 1'b1;
                  end
                  OP_UPDATE: begin
                     if (!any_match)     rsp_status_in = ST_MISSING;
                     else if (neg)       rsp_status_in = ST_NEG;
                     else                cmd.update_go = 1'b1;
                  end
                  OP_REMOVE: begin
                     if (!any_match)     rsp_status_in = ST_MISSING;
                     else                cmd.remove_go = 1'b1;
                  end
                  OP_READ: begin
                     if (slot_hit) begin
                        rsp_key_in    = rd_key;
                        rsp_amount_in = rd_amount;
                     end else begin
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  default: rsp_status_in = ST_OK;
               endcase
               if (cmd.insert_go)      count_in = count_ff + CNT_W'(1);
               else if (cmd.remove_go) count_in = count_ff - CNT_W'(1);
               rsp_entries_in = ENTRIES_W'(count_in);
               rsp_valid_in   = 1'b1;
               state_in       = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         op_ff   <= req_bus.operation;
         key_ff  <= req_bus.key;
         amt_ff  <= req_bus.amount;
         slot_ff <= req_bus.slot;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_amount_ff  <= rsp_amount_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.key_out    = rsp_key_ff;
   assign rsp_bus.amount_out = rsp_amount_ff;
   assign rsp_bus.entries    = rsp_entries_ff;

endmodule

`default_nettype wire

### rtl/core/kct_cell.sv
// One table entry: key/count storage, key compare, shift-down from neighbor.
// Depends on kct_pkg.
`default_nettype none

module kct_cell (
   input  wire logic                 clock,
   input  wire kct_pkg::cmd_type     cmd,
   input  wire kct_pkg::key_type     key_in,
   input  wire kct_pkg::amount_type  amount_in,
   input  wire logic                 valid,
   input  wire logic                 tail,
   input  wire logic                 seen_in,
   input  wire kct_pkg::key_type     next_key,
   input  wire kct_pkg::amount_type  next_amount,
   output logic                      seen_out,
   output kct_pkg::key_type          key_out,
   output kct_pkg::amount_type       amount_out
);
   import kct_pkg::*;

   key_type    stored_key_ff,    stored_key_in;
   amount_type stored_amount_ff, stored_amount_in;
   logic       match;

   assign match    = valid && (stored_key_ff == key_in);
   // seen_out: a match sits at this cell or below it
   assign seen_out = seen_in | match;

   always_comb begin
      stored_key_in    = stored_key_ff;
      stored_amount_in = stored_amount_ff;
      if (cmd.remove_go && seen_out) begin
         stored_key_in    = next_key;
         stored_amount_in = next_amount;
      end else if (cmd.update_go && match) begin
         stored_amount_in = amount_in;
      end else if (cmd.insert_go && tail) begin
         stored_key_in    = key_in;
         stored_amount_in = amount_in;
      end
   end

   always_ff @(posedge clock) begin
      stored_key_ff    <= stored_key_in;
      stored_amount_ff <= stored_amount_in;
   end

   assign key_out    = stored_key_ff;
   assign amount_out = stored_amount_ff;

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking bench for keyed_count_table: directed and random request words
// with random idling on both channels, results checked by a scoreboard.
// Depends on kct_pkg, kct_req_if, kct_rsp_if and the keyed_count_table RTL.
`default_nettype none

module testbench;
   import kct_pkg::*;

   localparam int POOL_SIZE      = 24;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 250;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 10;

   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      status_type             status;
      key_type                key_out;
      amount_type             amount_out;
      logic [ENTRIES_W-1:0]   entries;
   } table_result_type;

   class table_scoreboard;
      key_type           keys[DEPTH];
      amount_type        counts[DEPTH];
      int                used;
      table_result_type  expected_rsp[$];
      int                errors;

      function new();
         used   = 0;
         errors = 0;
      endfunction

      function int find_key(key_type k);
         for (int i = 0; i < used; i++)
            if (keys[i] == k) return i;
         return -1;
      endfunction

      // apply one accepted word to the shadow table, queue the result it gives
      function void note_request(op_type op, key_type k, logic signed [31:0] amt,
                                 logic [SLOT_W-1:0] s);
         table_result_type r;
         int pos;
         r   = '{ST_OK, '0, '0, '0};
         pos = find_key(k);
         case (op)
            OP_INSERT: begin
               if (used >= DEPTH) r.status = ST_FULL;
               else if (pos >= 0) r.status = ST_DUP;
               else if (amt < 0)  r.status = ST_NEG;
               else begin
                  keys[used]   = k;
                  counts[used] = amt[AMT_W-1:0];
                  used++;
               end
            end
            OP_UPDATE: begin
               // missing key wins over negative count
               if (pos < 0)      r.status = ST_MISSING;
               else if (amt < 0) r.status = ST_NEG;
               else              counts[pos] = amt[AMT_W-1:0];
            end
            OP_REMOVE: begin
               if (pos < 0) r.status = ST_MISSING;
               else begin
                  for (int j = pos; j + 1 < used; j++) begin
                     keys[j]   = keys[j+1];
                     counts[j] = counts[j+1];
                  end
                  used--;
               end
            end
            default: begin
               if (int'(s) < used) begin
                  r.key_out    = keys[s];
                  r.amount_out = counts[s];
               end else r.status = ST_EMPTY;
            end
         endcase
         r.entries = used[ENTRIES_W-1:0];
         expected_rsp.push_back(r);
      endfunction

      function void check_response(table_result_type got);
         table_result_type exp_r;
         if (expected_rsp.size() == 0) begin
            $display("%0t: result word with nothing pending: status %0d key %0d",
                     $time, got.status, got.key_out);
            $display("%0t:    amount %0d entries %0d", $time, got.amount_out, got.entries);
            errors++;
            return;
         end
         exp_r = expected_rsp.pop_front();
         if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status, got.status);
            errors++;
         end
         if (got.key_out !== exp_r.key_out) begin
            $display("%0t: key_out expected %0d got %0d", $time, exp_r.key_out, got.key_out);
            errors++;
         end
         if (got.amount_out !== exp_r.amount_out) begin
            $display("%0t: amount_out expected %0d got %0d", $time, exp_r.amount_out,
                     got.amount_out);
            errors++;
         end
         if (got.entries !== exp_r.entries) begin
            $display("%0t: entries expected %0d got %0d", $time, exp_r.entries, got.entries);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   kct_req_if req_bus ();
   kct_rsp_if rsp_bus ();

   keyed_count_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   table_scoreboard sb = new();
   key_type         key_pool[POOL_SIZE];
   bit              quiet    = 1'b0;
   bit              hold_rsp = 1'b0;
   int              idle_cycles = 0;

   always #10 clock = ~clock;

   // one request word; gap is a number of idle cycles before it
   task automatic send_word(op_type op, key_type k, logic signed [31:0] amt,
                            logic [SLOT_W-1:0] s, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.key       <= k;
      req_bus.amount    <= amt;
      req_bus.slot      <= s;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(op, k, amt, s);
   endtask

   function automatic int pick_gap();
      if (quiet || $urandom_range(3) != 0) return 0;
      return $urandom_range(1, 10);
   endfunction

   // mostly keys that are in the table or were used recently, so hits happen
   function automatic key_type pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 45) return key_pool[$urandom_range(POOL_SIZE-1)];
      if (r < 80 && sb.used != 0) return sb.keys[$urandom_range(sb.used-1)];
      return key_type'($urandom);
   endfunction

   function automatic logic signed [31:0] pick_amount();
      int r;
      r = $urandom_range(99);
      if (r < 5)  return 0;
      if (r < 10) return INT_MAX;
      if (r < 13) return INT_MIN;
      if (r < 25) return $urandom | 32'h8000_0000;
      if (r < 45) return $urandom_range(255);
      return $urandom & 32'h7fff_ffff;
   endfunction

   function automatic op_type pick_op(int insert_pct);
      if ($urandom_range(99) < insert_pct) return OP_INSERT;
      case ($urandom_range(5))
         0, 1:    return OP_UPDATE;
         2, 3:    return OP_REMOVE;
         default: return OP_READ;
      endcase
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response('{rsp_bus.status, rsp_bus.key_out, rsp_bus.amount_out,
                             rsp_bus.entries});
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else if (reset || (req_bus.valid && req_bus.ready) ||
                   (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : stimulus
      int             insert_pct;
      logic [SLOT_W-1:0] s;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_INSERT;
      req_bus.key       <= '0;
      req_bus.amount    <= '0;
      req_bus.slot      <= '0;
      key_pool[0] = INT_MIN;
      key_pool[1] = INT_MAX;
      key_pool[2] = 0;
      key_pool[3] = -1;
      key_pool[4] = 1;
      for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, check ordering, extremes, fill, full, shift on remove
      send_word(OP_READ,   0,       0,       0,  0);
      send_word(OP_REMOVE, 5,       0,       0,  pick_gap());
      send_word(OP_UPDATE, 5,       INT_MIN, 0,  pick_gap());
      send_word(OP_INSERT, INT_MIN, 0,       0,  pick_gap());
      send_word(OP_INSERT, INT_MAX, INT_MAX, 0,  pick_gap());
      send_word(OP_INSERT, INT_MIN, -1,      0,  pick_gap());
      send_word(OP_INSERT, 0,       INT_MIN, 0,  pick_gap());
      send_word(OP_UPDATE, INT_MAX, -1,      0,  pick_gap());
      send_word(OP_UPDATE, INT_MIN, INT_MAX, 0,  pick_gap());
      send_word(OP_READ,   0,       0,       1,  pick_gap());
      for (int i = 0; i < DEPTH - 2; i++)
         send_word(OP_INSERT, 32'sh5a5a_0000 ^ (i << 3) ^ (i << 28), 32'(i) * 977, 0,
                   pick_gap());
      send_word(OP_INSERT, 32'sh1234_5678, -1, 0,  pick_gap());
      send_word(OP_READ,   0,       0,       15, pick_gap());
      send_word(OP_REMOVE, INT_MIN, 0,       0,  pick_gap());
      send_word(OP_READ,   0,       0,       0,  pick_gap());
      send_word(OP_READ,   0,       0,       15, pick_gap());

      for (int ph = 0; ph < PHASES; ph++) begin
         quiet = (ph == PHASES - 1);
         // receiver goes away for a while; requests keep coming and back up
         if (ph == 1) hold_rsp = 1'b1;
         insert_pct = (ph % 3 == 0) ? 55 : (ph % 3 == 1) ? 25 : 40;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(15) == 0) key_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
            s = $urandom_range(15);
            send_word(pick_op(insert_pct), pick_key(), pick_amount(), s, pick_gap());
         end
         if (ph == 3) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (sb.expected_rsp.size() != 0);
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_rsp.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
